// File: hdl/ssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// shared constants and codes for the segment side classifier
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int IN_FIELDS      = 8;
    localparam int OUT_W          = 8;
    localparam int EPS_W          = 32;
    localparam logic [EPS_W-1:0] EPS_RESET = 32'd10995;

    // near test works on magnitudes below 2^34, scaled by 256
    localparam int MAG_W     = 34;
    localparam int LHS_SHIFT = 8;

    localparam int NUM_STAGES = 7;

    localparam logic [1:0] SIDE_FRONT = 2'b11;
    localparam logic [1:0] SIDE_ON    = 2'b00;
    localparam logic [1:0] SIDE_BACK  = 2'b01;

    localparam logic [1:0] PLACE_FRONT = 2'd0;
    localparam logic [1:0] PLACE_BACK  = 2'd1;
    localparam logic [1:0] PLACE_SPAN  = 2'd2;

endpackage : ssc_pkg
`default_nettype wire

// File: hdl/ssc_side.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_side
// side of one endpoint against the splitter line, stages one to six
// ----------------------------------------------------------------------------
module ssc_side import ssc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic [NUM_STAGES-1:0]             stage_en,
    input  wire logic signed [COORD_BITS-1:0]      line_x,
    input  wire logic signed [COORD_BITS-1:0]      line_y,
    input  wire logic signed [COORD_BITS-1:0]      line_dx,
    input  wire logic signed [COORD_BITS-1:0]      line_dy,
    input  wire logic signed [COORD_BITS-1:0]      pt_x,
    input  wire logic signed [COORD_BITS-1:0]      pt_y,
    input  wire logic [EPS_W+2*COORD_BITS-1:0]     rhs,
    output logic [1:0]                             side
);

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * COORD_BITS + 1;
    localparam int NW   = 2 * COORD_BITS + 2;
    localparam int AW   = (NW > MAG_W + 1) ? NW : MAG_W + 1;
    localparam int SQW  = 2 * MAG_W;
    localparam int LHW  = SQW + LHS_SHIFT;
    localparam int RW   = EPS_W + 2 * COORD_BITS;
    localparam int CMPW = (LHW > RW) ? LHW : RW;

    // stage 1: differences
    logic signed [DW-1:0]         ddx_reg, ddy_reg;
    logic signed [COORD_BITS-1:0] dx_reg, dy_reg;
    // stage 2: products
    logic signed [PW-1:0]         p1_reg, p2_reg;
    // stage 3: cross product
    logic signed [NW-1:0]         num_reg;
    // stage 4: magnitude
    logic                         neg_reg, zero_reg, far_reg;
    logic [MAG_W-1:0]             mag_reg;
    // stage 5: square
    logic                         neg5_reg, zero5_reg, far5_reg;
    logic [SQW-1:0]               sq_reg;
    // stage 6: side
    logic [1:0]                   side_reg;

    logic signed [AW-1:0] num_ext;
    logic [AW-1:0]        abs_next;
    logic [LHW-1:0]       lhs;
    logic                 on_line;
    logic [1:0]           side_next;

    always_comb begin
        num_ext  = AW'(num_reg);
        abs_next = num_reg[NW-1] ? AW'(-num_ext) : AW'(num_ext);
        lhs      = {sq_reg, {LHS_SHIFT{1'b0}}};
        on_line  = !far5_reg && (CMPW'(lhs) < CMPW'(rhs));
        if (on_line) begin
            side_next = SIDE_ON;
        end else if (!neg5_reg && !zero5_reg) begin
            side_next = SIDE_FRONT;
        end else begin
            side_next = SIDE_BACK;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            ddx_reg <= DW'(line_x) - DW'(pt_x);
            ddy_reg <= DW'(line_y) - DW'(pt_y);
            dx_reg  <= line_dx;
            dy_reg  <= line_dy;
        end
        if (stage_en[1]) begin
            p1_reg <= PW'(ddy_reg) * PW'(dx_reg);
            p2_reg <= PW'(ddx_reg) * PW'(dy_reg);
        end
        if (stage_en[2]) begin
            num_reg <= NW'(p1_reg) - NW'(p2_reg);
        end
        if (stage_en[3]) begin
            neg_reg  <= num_reg[NW-1];
            zero_reg <= (num_reg == '0);
            far_reg  <= |abs_next[AW-1:MAG_W];
            mag_reg  <= abs_next[MAG_W-1:0];
        end
        if (stage_en[4]) begin
            neg5_reg  <= neg_reg;
            zero5_reg <= zero_reg;
            far5_reg  <= far_reg;
            sq_reg    <= mag_reg * mag_reg;
        end
        if (stage_en[5]) begin
            side_reg <= side_next;
        end
    end

    assign side = side_reg;

endmodule : ssc_side
`default_nettype wire

// File: hdl/segment_side_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_side_classifier
// classifies a segment against a splitter line: side of each endpoint and
// front, back or spanning placement
//
// s_ channel: one request per segment, splitter and endpoints in tdata.
// m_ channel: one result per request, in request order.
// cfg channel: writes eps_sq_scaled, always ready; write only while idle.
// throughput: one request per cycle while m_tready is high, set by the
// seven-stage pipeline with at most one multiplier level per stage.
// reset: clears all valid bits and loads eps_sq_scaled with 10995.
// when the receiver stalls the output register holds its result, stages
// behind it keep filling empty slots, and s_tready drops once the whole
// pipeline is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_side_classifier import ssc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // splitter_x, splitter_y, splitter_dx, splitter_dy, start_x, start_y,
    // end_x, end_y
    input  wire logic [IN_FIELDS*FIELD_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // placement, start_side, end_side, zero pad
    output logic [OUT_W-1:0]                   m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [EPS_W-1:0]              cfg_data
);

    localparam int C  = COORD_BITS;
    localparam int LW = 2 * C;
    localparam int PPW = EPS_W + C;
    localparam int RW = EPS_W + 2 * C;

    logic [EPS_W-1:0]      eps_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    logic signed [C-1:0] line_x, line_y, line_dx, line_dy;
    logic signed [C-1:0] st_x, st_y, en_x, en_y;

    logic [C-1:0]   udx_reg, udy_reg;
    logic [LW-1:0]  ux2_reg, uy2_reg;
    logic [LW-1:0]  len2_reg;
    logic [PPW-1:0] pp_lo_reg, pp_hi_reg;
    logic [RW-1:0]  rhs_reg;
    logic [NUM_STAGES-2:0] fr_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic       fr_next;
    logic [1:0] s0_side, s1_side;
    logic [1:0] place_next;

    assign line_x  = $signed(s_tdata[0*FIELD_W +: C]);
    assign line_y  = $signed(s_tdata[1*FIELD_W +: C]);
    assign line_dx = $signed(s_tdata[2*FIELD_W +: C]);
    assign line_dy = $signed(s_tdata[3*FIELD_W +: C]);
    assign st_x    = $signed(s_tdata[4*FIELD_W +: C]);
    assign st_y    = $signed(s_tdata[5*FIELD_W +: C]);
    assign en_x    = $signed(s_tdata[6*FIELD_W +: C]);
    assign en_y    = $signed(s_tdata[7*FIELD_W +: C]);

    // stall chain: a stage advances when empty or when the next one advances
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_tready  = stage_en[0];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            eps_reg   <= EPS_RESET;
        end else begin
            if (cfg_valid) begin
                eps_reg <= cfg_data;
            end
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // orientation for a segment lying on the splitter
    always_comb begin
        if (line_dx != '0) begin
            fr_next = (!line_dx[C-1] && (en_x > st_x)) || (line_dx[C-1] && (en_x < st_x));
        end else begin
            fr_next = (line_dy > 0 && (en_y > st_y)) || (line_dy[C-1] && (en_y < st_y));
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            udx_reg   <= line_dx[C-1] ? (~line_dx + 1'b1) : line_dx;
            udy_reg   <= line_dy[C-1] ? (~line_dy + 1'b1) : line_dy;
            fr_reg[0] <= fr_next;
        end
        for (int k = 1; k < NUM_STAGES - 1; k++) begin
            if (stage_en[k]) begin
                fr_reg[k] <= fr_reg[k-1];
            end
        end
        if (stage_en[1]) begin
            ux2_reg <= LW'(udx_reg) * LW'(udx_reg);
            uy2_reg <= LW'(udy_reg) * LW'(udy_reg);
        end
        if (stage_en[2]) begin
            len2_reg <= ux2_reg + uy2_reg;
        end
        if (stage_en[3]) begin
            pp_lo_reg <= PPW'(eps_reg) * PPW'(len2_reg[C-1:0]);
            pp_hi_reg <= PPW'(eps_reg) * PPW'(len2_reg[LW-1:C]);
        end
        if (stage_en[4]) begin
            rhs_reg <= RW'(pp_lo_reg) + (RW'(pp_hi_reg) << C);
        end
        if (stage_en[6]) begin
            m_tdata_reg <= {2'b00, s1_side, s0_side, place_next};
        end
    end

    ssc_side #(
        .COORD_BITS (COORD_BITS)
    ) u_side_start (
        .aclk     (aclk),
        .stage_en (stage_en),
        .line_x   (line_x),
        .line_y   (line_y),
        .line_dx  (line_dx),
        .line_dy  (line_dy),
        .pt_x     (st_x),
        .pt_y     (st_y),
        .rhs      (rhs_reg),
        .side     (s0_side)
    );

    ssc_side #(
        .COORD_BITS (COORD_BITS)
    ) u_side_end (
        .aclk     (aclk),
        .stage_en (stage_en),
        .line_x   (line_x),
        .line_y   (line_y),
        .line_dx  (line_dx),
        .line_dy  (line_dy),
        .pt_x     (en_x),
        .pt_y     (en_y),
        .rhs      (rhs_reg),
        .side     (s1_side)
    );

    always_comb begin
        if (s0_side == SIDE_ON && s1_side == SIDE_ON) begin
            place_next = fr_reg[NUM_STAGES-2] ? PLACE_FRONT : PLACE_BACK;
        end else if (s0_side != SIDE_BACK && s1_side != SIDE_BACK) begin
            place_next = PLACE_FRONT;
        end else if (s0_side != SIDE_FRONT && s1_side != SIDE_FRONT) begin
            place_next = PLACE_BACK;
        end else begin
            place_next = PLACE_SPAN;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = m_tdata_reg;

endmodule : segment_side_classifier
`default_nettype wire
